### rtl/cell_grid_occupancy_map_assert.svh
// Assertion macros for the cell grid occupancy map RTL.
// Used by modules that check their own sequencing; needs no other file.
`ifndef CELL_GRID_OCCUPANCY_MAP_ASSERT_SVH
`define CELL_GRID_OCCUPANCY_MAP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CGOM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cgom assertion failed");

// Next-cycle implication, checked outside reset.
`define CGOM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cgom assertion failed");

`endif

### rtl/cgom_pkg.sv
// Shared types and codes for the cell grid occupancy map.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cgom_pkg;

    localparam logic [1:0] OP_PLACE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_OUT    = 2'd1;
    localparam logic [1:0] STAT_USED   = 2'd2;
    localparam logic [1:0] STAT_FAILED = 2'd3;

    localparam logic [1:0] KIND_EMPTY   = 2'd0;
    localparam logic [1:0] KIND_COVERED = 2'd1;
    localparam logic [1:0] KIND_ANCHOR  = 2'd2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b1;

    typedef struct packed {
        logic [1:0] opcode;
        logic [4:0] col;
        logic [4:0] row;
        logic [5:0] col_span;
        logic [5:0] row_span;
        logic [7:0] cell_id;
        logic       extra_line;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] entry_kind;
        logic [7:0] entry_cell;
        logic       any_extra_line;
    } out_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] id;
    } entry_t;

    typedef struct packed {
        logic   rd_en;
        logic   wr_en;
        entry_t wr_data;
    } ram_ctl_t;

    typedef enum logic [2:0] {
        ST_SWEEP_RST,
        ST_IDLE,
        ST_WALK,
        ST_TEST,
        ST_RDATA,
        ST_SWEEP_CLR,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### rtl/cgom_grid_ram.sv
// Single-port grid entry memory with registered read.
// Depends on cgom_pkg for the entry and control types.
`timescale 1ns / 1ps
`default_nettype none

module cgom_grid_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire                  aclk,
    input  cgom_pkg::ram_ctl_t   ctl,
    input  wire  [ADDR_W-1:0]    addr,
    output cgom_pkg::entry_t     rd_data
);

    cgom_pkg::entry_t mem [DEPTH];
    cgom_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[addr] <= ctl.wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/cgom_out_reg.sv
// Result register between the sequencer and the result channel.
// Depends on cgom_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module cgom_out_reg (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  load,
    input  cgom_pkg::out_item_t  load_data,
    output logic                 free,
    output logic                 m_valid,
    input  wire                  m_ready,
    output cgom_pkg::out_item_t  m_data
);

    logic                valid_reg;
    logic                valid_next;
    cgom_pkg::out_item_t data_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

### rtl/cgom_ctrl.sv
// Sequencer: place walk, entry read, reset and clear sweeps and sticky flags.
// Depends on cgom_pkg and cell_grid_occupancy_map_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "cell_grid_occupancy_map_assert.svh"

module cgom_ctrl #(
    parameter int MAX_COLS  = 32,
    parameter int MAX_ROWS  = 32,
    parameter int MAX_CELLS = 256,
    parameter int ADDR_W    = 10
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire  [5:0]           num_cols,
    input  wire  [5:0]           num_rows,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  cgom_pkg::in_item_t   s_data,
    output cgom_pkg::ram_ctl_t   ram_ctl,
    output logic [ADDR_W-1:0]    ram_addr,
    input  cgom_pkg::entry_t     ram_rd_data,
    input  wire                  out_free,
    output logic                 out_load,
    output cgom_pkg::out_item_t  out_data
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    cgom_pkg::state_t    state_reg, state_next;
    cgom_pkg::in_item_t  item_reg, item_next;
    cgom_pkg::out_item_t res_reg, res_next;
    logic [5:0]          x_reg, x_next, y_reg, y_next;
    logic [6:0]          x_end_reg, x_end_next, y_end_reg, y_end_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    logic                failed_reg, failed_next;
    logic                extra_reg, extra_next;

    function automatic logic in_grid(input logic [5:0] x, input logic [5:0] y,
                                     input logic [5:0] nc, input logic [5:0] nr);
        in_grid = (32'(x) < 32'(nc)) && (32'(x) < MAX_COLS) &&
                  (32'(y) < 32'(nr)) && (32'(y) < MAX_ROWS);
    endfunction

    function automatic logic [ADDR_W-1:0] grid_addr(input logic [5:0] x,
                                                    input logic [5:0] y);
        grid_addr = ADDR_W'(32'(y) * MAX_COLS + 32'(x));
    endfunction

    logic              s_accept;
    logic              in_rd_ok;
    logic              id_bad;
    logic              span_zero;
    logic              walk_ok;
    logic              entry_used;
    logic              anchor_pos;
    logic [6:0]        x_inc, y_inc;
    logic              y_wrap;
    logic              walk_last;
    logic              sweep_last;

    assign s_accept   = s_valid && s_ready;
    assign in_rd_ok   = in_grid({1'b0, s_data.col}, {1'b0, s_data.row}, num_cols, num_rows);
    assign id_bad     = 32'(s_data.cell_id) >= MAX_CELLS;
    assign span_zero  = (s_data.col_span == 6'd0) || (s_data.row_span == 6'd0);
    assign walk_ok    = in_grid(x_reg, y_reg, num_cols, num_rows);
    assign entry_used = ram_rd_data.kind != cgom_pkg::KIND_EMPTY;
    assign anchor_pos = (x_reg == {1'b0, item_reg.col}) && (y_reg == {1'b0, item_reg.row});
    assign x_inc      = {1'b0, x_reg} + 7'd1;
    assign y_inc      = {1'b0, y_reg} + 7'd1;
    assign y_wrap     = y_inc == y_end_reg;
    assign walk_last  = y_wrap && (x_inc == x_end_reg);
    assign sweep_last = cnt_reg == LAST_ADDR;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cgom_pkg::ST_SWEEP_RST: begin
                if (sweep_last) begin
                    state_next = cgom_pkg::ST_IDLE;
                end
            end
            cgom_pkg::ST_SWEEP_CLR: begin
                if (sweep_last) begin
                    state_next = cgom_pkg::ST_DONE;
                end
            end
            cgom_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.opcode)
                        cgom_pkg::OP_PLACE: begin
                            if (failed_reg || id_bad || span_zero) begin
                                state_next = cgom_pkg::ST_DONE;
                            end else begin
                                state_next = cgom_pkg::ST_WALK;
                            end
                        end
                        cgom_pkg::OP_READ: begin
                            state_next = in_rd_ok ? cgom_pkg::ST_RDATA : cgom_pkg::ST_DONE;
                        end
                        cgom_pkg::OP_CLEAR: begin
                            state_next = cgom_pkg::ST_SWEEP_CLR;
                        end
                        default: begin
                            state_next = cgom_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            cgom_pkg::ST_WALK: begin
                state_next = walk_ok ? cgom_pkg::ST_TEST : cgom_pkg::ST_DONE;
            end
            cgom_pkg::ST_TEST: begin
                if (entry_used || walk_last) begin
                    state_next = cgom_pkg::ST_DONE;
                end else begin
                    state_next = cgom_pkg::ST_WALK;
                end
            end
            cgom_pkg::ST_RDATA: begin
                state_next = cgom_pkg::ST_DONE;
            end
            cgom_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = cgom_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cgom_pkg::ST_SWEEP_RST;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready         = 1'b0;
        out_load        = 1'b0;
        ram_ctl.rd_en   = 1'b0;
        ram_ctl.wr_en   = 1'b0;
        ram_ctl.wr_data = '0;
        ram_addr        = grid_addr(x_reg, y_reg);
        case (state_reg)
            cgom_pkg::ST_SWEEP_RST, cgom_pkg::ST_SWEEP_CLR: begin
                ram_ctl.wr_en = 1'b1;
                ram_addr      = cnt_reg;
            end
            cgom_pkg::ST_IDLE: begin
                s_ready       = 1'b1;
                ram_ctl.rd_en = s_valid && (s_data.opcode == cgom_pkg::OP_READ) && in_rd_ok;
                ram_addr      = grid_addr({1'b0, s_data.col}, {1'b0, s_data.row});
            end
            cgom_pkg::ST_WALK: begin
                ram_ctl.rd_en = walk_ok;
            end
            cgom_pkg::ST_TEST: begin
                ram_ctl.wr_en = !entry_used;
                if (anchor_pos) begin
                    ram_ctl.wr_data.kind = cgom_pkg::KIND_ANCHOR;
                    ram_ctl.wr_data.id   = item_reg.cell_id;
                end else begin
                    ram_ctl.wr_data.kind = cgom_pkg::KIND_COVERED;
                end
            end
            cgom_pkg::ST_DONE: begin
                out_load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        out_data                = res_reg;
        out_data.any_extra_line = extra_reg;
    end

    // datapath
    always_comb begin
        item_next   = item_reg;
        res_next    = res_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        x_end_next  = x_end_reg;
        y_end_next  = y_end_reg;
        cnt_next    = cnt_reg;
        failed_next = failed_reg;
        extra_next  = extra_reg;
        case (state_reg)
            cgom_pkg::ST_SWEEP_RST, cgom_pkg::ST_SWEEP_CLR: begin
                cnt_next = cnt_reg + ADDR_W'(1);
            end
            cgom_pkg::ST_IDLE: begin
                if (s_accept) begin
                    item_next  = s_data;
                    res_next   = '0;
                    x_next     = {1'b0, s_data.col};
                    y_next     = {1'b0, s_data.row};
                    x_end_next = {2'b0, s_data.col} + {1'b0, s_data.col_span};
                    y_end_next = {2'b0, s_data.row} + {1'b0, s_data.row_span};
                    cnt_next   = '0;
                    case (s_data.opcode)
                        cgom_pkg::OP_PLACE: begin
                            if (failed_reg) begin
                                res_next.status = cgom_pkg::STAT_FAILED;
                            end else begin
                                // extra line counts even if this place fails
                                if (s_data.extra_line) begin
                                    extra_next = 1'b1;
                                end
                                if (id_bad) begin
                                    failed_next     = 1'b1;
                                    res_next.status = cgom_pkg::STAT_OUT;
                                end
                            end
                        end
                        cgom_pkg::OP_READ: begin
                            if (!in_rd_ok) begin
                                res_next.status = failed_reg ? cgom_pkg::STAT_FAILED
                                                             : cgom_pkg::STAT_OUT;
                            end
                        end
                        cgom_pkg::OP_CLEAR: begin
                            failed_next = 1'b0;
                            extra_next  = 1'b0;
                        end
                        default: begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            cgom_pkg::ST_WALK: begin
                if (!walk_ok) begin
                    failed_next     = 1'b1;
                    res_next.status = cgom_pkg::STAT_OUT;
                end
            end
            cgom_pkg::ST_TEST: begin
                if (entry_used) begin
                    failed_next     = 1'b1;
                    res_next.status = cgom_pkg::STAT_USED;
                end else if (y_wrap) begin
                    y_next = {1'b0, item_reg.row};
                    x_next = x_inc[5:0];
                end else begin
                    y_next = y_inc[5:0];
                end
            end
            cgom_pkg::ST_RDATA: begin
                res_next.entry_kind = ram_rd_data.kind;
                res_next.entry_cell = (ram_rd_data.kind == cgom_pkg::KIND_ANCHOR)
                                      ? ram_rd_data.id : 8'd0;
                res_next.status     = failed_reg ? cgom_pkg::STAT_FAILED : cgom_pkg::STAT_OK;
            end
            default: begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= cgom_pkg::ST_SWEEP_RST;
            cnt_reg    <= '0;
            failed_reg <= 1'b0;
            extra_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            failed_reg <= failed_next;
            extra_reg  <= extra_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        res_reg   <= res_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        x_end_reg <= x_end_next;
        y_end_reg <= y_end_next;
    end

    `CGOM_ASSERT_IMPL(a_no_rd_wr_overlap, aclk, aresetn, ram_ctl.wr_en, !ram_ctl.rd_en)
    `CGOM_ASSERT_IMPL(a_test_follows_read, aclk, aresetn, state_reg == cgom_pkg::ST_TEST, $past(ram_ctl.rd_en))
    `CGOM_ASSERT_IMPL(a_walk_writes_empty, aclk, aresetn, (state_reg == cgom_pkg::ST_TEST) && ram_ctl.wr_en, ram_rd_data.kind == cgom_pkg::KIND_EMPTY)
    `CGOM_ASSERT_NEXT(a_failed_place_inert, aclk, aresetn, s_accept && (s_data.opcode == cgom_pkg::OP_PLACE) && failed_reg, failed_reg && $stable(extra_reg))

endmodule

`default_nettype wire

### rtl/cell_grid_occupancy_map.sv
// Cell grid occupancy map top level: config registers, sequencer, grid memory,
// result register. Depends on cgom_pkg, cgom_ctrl, cgom_grid_ram, cgom_out_reg.
//
//   channel  ports                         payload
//   -------  ----------------------------  ----------------------
//   input    s_valid / s_ready / s_data    cgom_pkg::in_item_t
//   result   m_valid / m_ready / m_data    cgom_pkg::out_item_t
//   config   cfg_wr_en / cfg_addr / data   6-bit num_cols, num_rows
//
// The single grid memory port sets the pace of place, read and clear:
// each entry is read, then checked and written.
// After reset a clearing pass over the MAX_COLS*MAX_ROWS entries (1024 by
// default) empties the grid; s_ready stays low during it.
// s_ready is high while no transaction is in work; a finished result waits in
// the result register, so a stalled m_ready only holds the next result back.
`timescale 1ns / 1ps
`default_nettype none

module cell_grid_occupancy_map #(
    parameter int MAX_COLS  = 32,
    parameter int MAX_ROWS  = 32,
    parameter int MAX_CELLS = 256
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_wr_en,
    input  wire  [cgom_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire  [cgom_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  cgom_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  wire                               m_ready,
    output cgom_pkg::out_item_t               m_data
);

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [5:0] num_cols_reg, num_cols_next;
    logic [5:0] num_rows_reg, num_rows_next;

    always_comb begin
        num_cols_next = num_cols_reg;
        num_rows_next = num_rows_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                cgom_pkg::CFG_NUM_COLS: num_cols_next = cfg_wr_data;
                cgom_pkg::CFG_NUM_ROWS: num_rows_next = cfg_wr_data;
                default: begin
                    num_cols_next = num_cols_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cols_reg <= 6'd1;
            num_rows_reg <= 6'd1;
        end else begin
            num_cols_reg <= num_cols_next;
            num_rows_reg <= num_rows_next;
        end
    end

    cgom_pkg::ram_ctl_t  ram_ctl;
    logic [ADDR_W-1:0]   ram_addr;
    cgom_pkg::entry_t    ram_rd_data;
    logic                out_free;
    logic                out_load;
    cgom_pkg::out_item_t out_data;

    cgom_ctrl #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .MAX_CELLS (MAX_CELLS),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .num_cols    (num_cols_reg),
        .num_rows    (num_rows_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .ram_ctl     (ram_ctl),
        .ram_addr    (ram_addr),
        .ram_rd_data (ram_rd_data),
        .out_free    (out_free),
        .out_load    (out_load),
        .out_data    (out_data)
    );

    cgom_grid_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .ctl     (ram_ctl),
        .addr    (ram_addr),
        .rd_data (ram_rd_data)
    );

    cgom_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (out_load),
        .load_data (out_data),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
